>>> rtl/core/mpfd_pkg.sv
// Shared types and constants of the page framebuffer draw unit.
`timescale 1ns / 1ps

package mpfd_pkg;

  typedef enum logic [2:0] {
    MODE_PIXEL = 3'd0,
    MODE_HLINE = 3'd1,
    MODE_VLINE = 3'd2,
    MODE_RING  = 3'd3,
    MODE_DISC  = 3'd4,
    MODE_CLEAR = 3'd5,
    MODE_READ  = 3'd6,
    MODE_TAKE  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    COL_BLACK  = 2'd0,
    COL_WHITE  = 2'd1,
    COL_INVERT = 2'd2,
    COL_KEEP   = 2'd3
  } colour_t;

  localparam logic [7:0] WIN_NONE_LO = 8'hFF;
  localparam logic [7:0] WIN_NONE_HI = 8'h00;

  // Command as classified by the front end.
  typedef struct packed {
    mode_t             mode;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [7:0]        extent;
    colour_t           colour;
    logic              on_panel;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] win_left;
    logic [7:0] win_right;
    logic [7:0] win_top;
    logic [7:0] win_bottom;
    logic       win_empty;
  } result_t;

  // Visible row count: 64 or 32, capped by the page count.
  function automatic logic [7:0] panel_rows(input logic tall, input int max_pages);
    int r;
    r = tall ? 64 : 32;
    if (r > max_pages * 8) r = max_pages * 8;
    return 8'(r);
  endfunction

endpackage

>>> rtl/core/mpfd_front.sv
// Front end: takes command words, checks the start point, queues them.
`timescale 1ns / 1ps

module mpfd_front #(
  parameter int COLUMNS   = 128,
  parameter int MAX_PAGES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [31:0]    s_tdata,
  input  logic [2:0]     s_tuser,
  input  logic           tall_panel,
  input  logic           init_busy,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output mpfd_pkg::cmd_t cmd
);
  import mpfd_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       in_cmd;
  logic [7:0] rows;
  logic       push;
  logic       pop;

  assign rows = panel_rows(tall_panel, MAX_PAGES);

  always_comb begin
    in_cmd.mode   = mode_t'(s_tuser);
    in_cmd.pos_x  = s_tdata[7:0];
    in_cmd.pos_y  = s_tdata[15:8];
    in_cmd.extent = s_tdata[23:16];
    in_cmd.colour = colour_t'(s_tdata[25:24]);
    in_cmd.on_panel = !s_tdata[7] && ({1'b0, s_tdata[7:0]} < 9'(COLUMNS)) &&
                      !s_tdata[15] && (s_tdata[15:8] < rows);
  end

  assign s_tready  = (count != 2'd2) && !init_busy;
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

>>> rtl/core/mpfd_back.sv
// Back end: shape sequencer, span clipper, byte read-modify-write, store.
`timescale 1ns / 1ps

module mpfd_back #(
  parameter int COLUMNS   = 128,
  parameter int MAX_PAGES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tall_panel,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  mpfd_pkg::cmd_t    cmd,
  output logic              init_busy,
  output logic              res_valid,
  input  logic              res_ready,
  output mpfd_pkg::result_t res
);
  import mpfd_pkg::*;

  localparam int DEPTH  = COLUMNS * MAX_PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic signed [11:0] COLS_S  = 12'(COLUMNS);
  localparam logic signed [11:0] ONE_S   = 12'sd1;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_SHAPE, ST_CLIP, ST_PAINT_RD, ST_PAINT_WR,
    ST_FETCH, ST_FETCH_DATA, ST_CLEAR, ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    PH_PRE, PH_LOOP1, PH_PRE2, PH_LOOP2, PH_DONE
  } phase_t;

  state_t state;
  phase_t phase;
  mode_t  mode;
  colour_t colour;
  logic signed [11:0] cx, cy, r;
  logic signed [11:0] a, b, err, stop;
  logic [2:0] k;
  // raw span from the sequencer
  logic sp_vert;
  logic signed [11:0] sp_x, sp_y, sp_len;
  // clipped span being painted
  logic pv;
  logic [7:0] lo, hi, fixed, cur;
  logic [7:0] win_left, win_right, win_top, win_bottom;
  logic [7:0] rd_byte;
  logic [ADDR_W-1:0] clr_cnt;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;

  logic [7:0] rows;
  logic signed [11:0] rows_s;
  assign rows   = panel_rows(tall_panel, MAX_PAGES);
  assign rows_s = {4'b0, rows};

  // ---------------- span generator ----------------
  logic g_vert, g_emit;
  logic signed [11:0] dx, dy, g_len;
  logic [2:0] kmax;
  logic loop_run;

  assign loop_run = (b >= a);

  always_comb begin
    g_vert = 1'b0;
    g_emit = 1'b1;
    dx     = '0;
    dy     = '0;
    g_len  = ONE_S;
    kmax   = 3'd0;
    case (mode)
      MODE_HLINE: g_len = r;
      MODE_VLINE: begin
        g_vert = 1'b1;
        g_len  = r;
      end
      MODE_RING: begin
        if (phase == PH_PRE) begin
          kmax = 3'd3;
          case (k)
            3'd0:    dx = -r;
            3'd1:    dx = r;
            3'd2:    dy = -r;
            default: dy = r;
          endcase
        end else begin
          kmax   = 3'd7;
          g_emit = !k[2] || (a != b);
          case (k)
            3'd0: begin dx = b;  dy = a;  end
            3'd1: begin dx = -b; dy = a;  end
            3'd2: begin dx = b;  dy = -a; end
            3'd3: begin dx = -b; dy = -a; end
            3'd4: begin dx = a;  dy = b;  end
            3'd5: begin dx = -a; dy = b;  end
            3'd6: begin dx = a;  dy = -b; end
            default: begin dx = -a; dy = -b; end
          endcase
        end
      end
      MODE_DISC: begin
        case (phase)
          PH_PRE: begin
            g_vert = 1'b1;
            dy     = -r;
            g_len  = (r <<< 1) + ONE_S;
          end
          PH_LOOP1: begin
            g_vert = 1'b1;
            kmax   = 3'd3;
            g_emit = !k[1] || (colour != COL_INVERT);
            case (k)
              3'd0: begin dx = -a; dy = -b; g_len = (b <<< 1) + ONE_S; end
              3'd1: begin dx = a;  dy = -b; g_len = (b <<< 1) + ONE_S; end
              3'd2: begin dx = -b; dy = -a; g_len = (a <<< 1) + ONE_S; end
              default: begin dx = b; dy = -a; g_len = (a <<< 1) + ONE_S; end
            endcase
          end
          PH_PRE2: begin
            kmax  = 3'd1;
            g_len = r - stop + ONE_S;
            dx    = k[0] ? -r : stop;
          end
          default: begin
            kmax  = 3'd3;
            g_len = b - stop + ONE_S;
            case (k)
              3'd0: begin dx = stop; dy = -a; end
              3'd1: begin dx = stop; dy = a;  end
              3'd2: begin dx = -b;   dy = -a; end
              default: begin dx = -b; dy = a; end
            endcase
          end
        endcase
      end
      default: ;
    endcase
  end

  // midpoint step: a counts up, b counts down
  logic signed [11:0] a1, b1, err_n;
  always_comb begin
    a1 = a + ONE_S;
    b1 = b - ONE_S;
    if (err[11]) err_n = err + (a1 <<< 1) + ONE_S;
    else         err_n = err + ((a1 - b1 + ONE_S) <<< 1);
  end

  // ---------------- clipper ----------------
  logic signed [11:0] hi_w, lo_c, hi_c, lim;
  logic c_skip;
  always_comb begin
    hi_w = (sp_vert ? sp_y : sp_x) + sp_len - ONE_S;
    lim  = sp_vert ? rows_s - ONE_S : COLS_S - ONE_S;
    lo_c = sp_vert ? (sp_y[11] ? '0 : sp_y) : (sp_x[11] ? '0 : sp_x);
    hi_c = (hi_w > lim) ? lim : hi_w;
    if (sp_vert) c_skip = (sp_len <= 0) || sp_x[11] || (sp_x >= COLS_S);
    else         c_skip = (sp_len <= 0) || sp_y[11] || (sp_y >= rows_s);
    c_skip = c_skip || (lo_c > hi_c);
  end

  // ---------------- paint datapath ----------------
  logic [4:0] page;
  logic [7:0] col;
  logic [ADDR_W-1:0] paint_addr, addr;
  logic last;
  logic [2:0] end_b;
  logic [7:0] mask, wdata;
  logic we;

  always_comb begin
    page       = pv ? cur[7:3] : fixed[7:3];
    col        = pv ? fixed : cur;
    paint_addr = ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    last       = pv ? ({cur[7:3], 3'b111} >= hi) : (cur == hi);
    end_b      = last ? hi[2:0] : 3'b111;
    mask       = pv ? ((8'hFF << cur[2:0]) & (8'hFF >> (3'd7 - end_b)))
                    : (8'd1 << fixed[2:0]);
    case (colour)
      COL_BLACK:  wdata = rdata & ~mask;
      COL_WHITE:  wdata = rdata | mask;
      COL_INVERT: wdata = rdata ^ mask;
      default:    wdata = rdata;
    endcase
  end

  assign addr = (state == ST_INIT || state == ST_CLEAR) ? clr_cnt : paint_addr;
  assign we   = (state == ST_INIT || state == ST_CLEAR || state == ST_PAINT_WR);

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= (state == ST_PAINT_WR) ? wdata : 8'h00;
    rdata <= mem[addr];
  end

  // ---------------- handshake and result ----------------
  assign cmd_ready = (state == ST_IDLE);
  assign init_busy = (state == ST_INIT);
  assign res_valid = (state == ST_RESULT);

  always_comb begin
    res.read_data  = rd_byte;
    res.win_left   = win_left;
    res.win_right  = win_right;
    res.win_top    = win_top;
    res.win_bottom = win_bottom;
    res.win_empty  = (win_top > win_bottom) || (win_left > win_right);
  end

  // span bounds in window terms
  logic [7:0] w_l, w_r, w_t, w_b;
  assign w_l = pv ? fixed : lo;
  assign w_r = pv ? fixed : hi;
  assign w_t = pv ? lo : fixed;
  assign w_b = pv ? hi : fixed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      clr_cnt    <= '0;
      win_left   <= WIN_NONE_LO;
      win_right  <= WIN_NONE_HI;
      win_top    <= WIN_NONE_LO;
      win_bottom <= WIN_NONE_HI;
      phase      <= PH_DONE;
      k          <= '0;
    end else begin
      case (state)
        ST_INIT, ST_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            if (state == ST_INIT) begin
              state <= ST_IDLE;
            end else begin
              win_left   <= 8'd0;
              win_right  <= 8'(COLUMNS - 1);
              win_top    <= 8'd0;
              win_bottom <= rows - 8'd1;
              state      <= ST_RESULT;
            end
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            mode    <= cmd.mode;
            colour  <= cmd.colour;
            cx      <= {{4{cmd.pos_x[7]}}, cmd.pos_x};
            cy      <= {{4{cmd.pos_y[7]}}, cmd.pos_y};
            r       <= {4'b0, cmd.extent};
            a       <= ONE_S;
            b       <= {4'b0, cmd.extent};
            err     <= ONE_S - {4'b0, cmd.extent};
            k       <= '0;
            phase   <= PH_PRE;
            rd_byte <= 8'h00;
            pv      <= 1'b0;
            fixed   <= cmd.pos_y;
            cur     <= cmd.pos_x;
            clr_cnt <= '0;
            case (cmd.mode)
              MODE_PIXEL, MODE_HLINE, MODE_VLINE:
                state <= cmd.on_panel ? ST_SHAPE : ST_RESULT;
              MODE_RING, MODE_DISC:
                state <= (cmd.extent == 8'd0) ? ST_RESULT : ST_SHAPE;
              MODE_CLEAR: state <= ST_CLEAR;
              MODE_READ:  state <= cmd.on_panel ? ST_FETCH : ST_RESULT;
              default:    state <= ST_RESULT;
            endcase
          end
        end
        ST_SHAPE: begin
          if (phase == PH_DONE) begin
            state <= ST_RESULT;
          end else if ((phase == PH_LOOP1 || phase == PH_LOOP2) && !loop_run) begin
            if (mode == MODE_DISC && phase == PH_LOOP1 && colour == COL_INVERT) begin
              stop  <= a;
              a     <= ONE_S;
              b     <= r;
              err   <= ONE_S - r;
              k     <= '0;
              phase <= PH_PRE2;
            end else begin
              state <= ST_RESULT;
            end
          end else begin
            sp_vert <= g_vert;
            sp_x    <= cx + dx;
            sp_y    <= cy + dy;
            sp_len  <= g_len;
            if (g_emit) state <= ST_CLIP;
            if (k == kmax) begin
              k <= '0;
              case (phase)
                PH_PRE: phase <= (mode == MODE_RING || mode == MODE_DISC)
                                 ? PH_LOOP1 : PH_DONE;
                PH_PRE2: phase <= PH_LOOP2;
                default: begin
                  a   <= a1;
                  err <= err_n;
                  if (!err[11]) b <= b1;
                end
              endcase
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        ST_CLIP: begin
          if (c_skip) begin
            state <= ST_SHAPE;
          end else begin
            pv    <= sp_vert;
            lo    <= lo_c[7:0];
            hi    <= hi_c[7:0];
            cur   <= lo_c[7:0];
            fixed <= sp_vert ? sp_x[7:0] : sp_y[7:0];
            state <= ST_PAINT_RD;
          end
        end
        ST_PAINT_RD: begin
          // widening again with the same span changes nothing
          if (win_left > w_l) win_left <= w_l;
          if (win_right < w_r) win_right <= w_r;
          if (win_top > w_t) win_top <= w_t;
          if (win_bottom < w_b) win_bottom <= w_b;
          state <= ST_PAINT_WR;
        end
        ST_PAINT_WR: begin
          if (last) begin
            state <= ST_SHAPE;
          end else begin
            cur   <= pv ? {cur[7:3] + 5'd1, 3'b000} : cur + 8'd1;
            state <= ST_PAINT_RD;
          end
        end
        ST_FETCH: state <= ST_FETCH_DATA;
        ST_FETCH_DATA: begin
          rd_byte <= rdata;
          state   <= ST_RESULT;
        end
        ST_RESULT: begin
          if (res_ready) begin
            if (mode == MODE_TAKE) begin
              win_left   <= WIN_NONE_LO;
              win_right  <= WIN_NONE_HI;
              win_top    <= WIN_NONE_LO;
              win_bottom <= WIN_NONE_HI;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/mono_page_framebuffer_draw_unit.sv
// Top level of the page framebuffer draw unit: config register, output register.
`timescale 1ns / 1ps

// Each command goes from the front-end queue to the back end, and its result word
// is registered into m_tdata. Drawing sequences and clips each generated span, then
// reads and writes each byte touched (one per column for horizontal spans, one per page
// for vertical ones). Clear sweeps the whole store. One command at a time.
// Reset: synchronous; the store is swept to zero, during which no word is taken;
// window resets to empty, tall_panel to 1.
module mono_page_framebuffer_draw_unit #(
  parameter int COLUMNS   = 128,
  parameter int MAX_PAGES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pos_x[7:0], pos_y[15:8], extent[23:16], colour[25:24]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // read_data, win_left, win_right, win_top, win_bottom,
                                 // win_empty[40]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // tall_panel
);
  import mpfd_pkg::*;

  logic    tall_panel;
  logic    init_busy;
  logic    cmd_valid, cmd_ready;
  cmd_t    cmd;
  logic    res_valid, res_ready;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) tall_panel <= 1'b1;
    else if (cfg_valid) tall_panel <= cfg_data;
  end

  mpfd_front #(.COLUMNS(COLUMNS), .MAX_PAGES(MAX_PAGES)) u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .tall_panel, .init_busy, .cmd_valid, .cmd_ready, .cmd
  );

  mpfd_back #(.COLUMNS(COLUMNS), .MAX_PAGES(MAX_PAGES)) u_back (
    .clk, .rst, .tall_panel, .cmd_valid, .cmd_ready, .cmd,
    .init_busy, .res_valid, .res_ready, .res
  );

  // output word register; the back end moves on once its word lands here
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {7'b0, res.win_empty, res.win_bottom, res.win_top,
                  res.win_right, res.win_left, res.read_data};
    end
  end

endmodule
